### design/ssdq_pkg.sv
`default_nettype none

package ssdq_pkg;

  // Default sizes of the draw list and of the animation table.
  localparam int QUEUE_DEPTH_DEF  = 32;
  localparam int SPRITE_COUNT_DEF = 256;

  // Command codes.
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_ADD     = 3'd1;
  localparam logic [2:0] CMD_SUBMIT  = 3'd2;
  localparam logic [2:0] CMD_LOOP    = 3'd3;
  localparam logic [2:0] CMD_REVERSE = 3'd4;
  localparam logic [2:0] CMD_RSTFRM  = 3'd5;
  localparam logic [2:0] CMD_QUERY   = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // A stored frame of all ones asks for the animated frame.
  localparam logic [8:0] FRAME_AUTO = 9'h1FF;

  // One draw job as held in a cell.
  typedef struct packed {
    logic [7:0]  sprite;
    logic [8:0]  frames;
    logic [8:0]  frame;
    logic [7:0]  layer;
    logic [10:0] x;
    logic [10:0] y;
    logic [7:0]  style;
  } job_t;

  // One entry of the animation table.
  typedef struct packed {
    logic [7:0] frame;
    logic       loop;
    logic       reverse;
    logic       dirty;
  } anim_t;

  // Source of the next value of a cell.
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_NEW,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_WRAP
  } sel_t;

  // Control handed from the chain to each cell.
  typedef struct packed {
    sel_t sel;
    logic valid;
  } cell_ctl_t;

  // Sprite number modulo the table size, by restoring subtraction.
  function automatic logic [11:0] sprite_mod(input logic [7:0] v, input int count);
    int r;
    r = int'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (count << k)) begin
        r = r - (count << k);
      end
    end
    return 12'(r);
  endfunction

endpackage

`default_nettype wire

### design/ssdq_cell.sv
`default_nettype none

module ssdq_cell (
  input  wire                     clk,
  input  ssdq_pkg::cell_ctl_t     ctl,
  input  ssdq_pkg::job_t          new_job,
  input  ssdq_pkg::job_t          left,
  input  ssdq_pkg::job_t          right,
  input  ssdq_pkg::job_t          wrap,
  output logic                    gt,
  output ssdq_pkg::job_t          q
);

  // The new job sorts before this entry on layer, then on signed y.
  assign gt = ctl.valid &&
              ((new_job.layer < q.layer) ||
               ((new_job.layer == q.layer) && ($signed(new_job.y) < $signed(q.y))));

  // Load from the chosen neighbour or keep the entry.
  always_ff @(posedge clk) begin
    case (ctl.sel)
      ssdq_pkg::SEL_NEW:   q <= new_job;
      ssdq_pkg::SEL_LEFT:  q <= left;
      ssdq_pkg::SEL_RIGHT: q <= right;
      ssdq_pkg::SEL_WRAP:  q <= wrap;
      default:             q <= q;
    endcase
  end

endmodule

`default_nettype wire

### design/ssdq_chain.sv
`default_nettype none

module ssdq_chain #(
  parameter int QUEUE_DEPTH = ssdq_pkg::QUEUE_DEPTH_DEF,
  localparam int TW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                    clk,
  input  wire                    ins,
  input  wire                    rot,
  input  ssdq_pkg::job_t         new_job,
  input  wire [TW-1:0]           total,
  input  wire [8:0]              wrap_frame,
  output ssdq_pkg::job_t         head,
  output logic [TW-1:0]          at,
  output logic                   full
);

  ssdq_pkg::job_t            q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    gt;
  logic [QUEUE_DEPTH-1:0]    gt_prev;
  ssdq_pkg::job_t            wrap;
  logic [TW-1:0]             at_idx;

  assign full = (total == TW'(QUEUE_DEPTH));
  assign head = q[0];

  // The head re-enters at the tail, with its resolved frame during emission.
  always_comb begin
    wrap       = q[0];
    wrap.frame = wrap_frame;
  end

  genvar i;
  for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    ssdq_pkg::cell_ctl_t ctl;
    ssdq_pkg::job_t      left;
    ssdq_pkg::job_t      right;

    if (i == 0) begin : g_first
      assign gt_prev[i] = 1'b0;
      assign left       = '0;
    end else begin : g_inner
      assign gt_prev[i] = gt[i-1];
      assign left       = q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = q[i+1];
    end

    // Insert shifts the entries after the slot right; a submit step rotates left.
    // The first free cell takes the old last entry unless the new job goes at the end.
    always_comb begin
      ctl.valid = (TW'(i) < total);
      ctl.sel   = ssdq_pkg::SEL_HOLD;
      if (ins && !full) begin
        if (gt[i]) begin
          ctl.sel = gt_prev[i] ? ssdq_pkg::SEL_LEFT : ssdq_pkg::SEL_NEW;
        end else if (TW'(i) == total) begin
          ctl.sel = gt_prev[i] ? ssdq_pkg::SEL_LEFT : ssdq_pkg::SEL_NEW;
        end
      end else if (rot) begin
        if (TW'(i) + TW'(1) == total) begin
          ctl.sel = ssdq_pkg::SEL_WRAP;
        end else if (TW'(i) + TW'(1) < total) begin
          ctl.sel = ssdq_pkg::SEL_RIGHT;
        end
      end
    end

    ssdq_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .new_job (new_job),
      .left    (left),
      .right   (right),
      .wrap    (wrap),
      .gt      (gt[i]),
      .q       (q[i])
    );
  end

  // Insert slot: the first entry that sorts after the new job, else the end.
  always_comb begin
    at_idx = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      if (gt[k] && !gt_prev[k]) begin
        at_idx = at_idx | TW'(k);
      end
    end
    at = (gt == '0) ? total : at_idx;
  end

endmodule

`default_nettype wire

### design/sorted_sprite_draw_queue.sv
// Add and clear leave busy low; an add reply appears the cycle after the transfer.
// Table commands raise busy; a query reply follows in the cycle after.
// A submit runs an emission pass; when the animation ticks, an advance pass and a
// dirty restore pass go first. Each pass reads every job's table entry in turn,
// and the advance and restore passes write it back. After reset busy stays high
// while the table is filled. Results last one cycle each and cannot be stalled.
`default_nettype none

module sorted_sprite_draw_queue #(
  parameter int QUEUE_DEPTH  = ssdq_pkg::QUEUE_DEPTH_DEF,
  parameter int SPRITE_COUNT = ssdq_pkg::SPRITE_COUNT_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire  [2:0]        cmd,
  input  wire  [7:0]        sprite_id,
  input  wire  [8:0]        num_frames,
  input  wire  signed [8:0] frame_req,
  input  wire  [7:0]        layer,
  input  wire  signed [10:0] pos_x,
  input  wire  signed [10:0] pos_y,
  input  wire  [7:0]        draw_style,
  input  wire               flag,
  input  wire               first_cycle,
  output logic              valid,
  output logic [1:0]        kind,
  output logic signed [6:0] position,
  output logic              stored,
  output logic [7:0]        out_sprite,
  output logic signed [8:0] out_frame,
  output logic signed [10:0] out_x,
  output logic signed [10:0] out_y,
  output logic [7:0]        out_style,
  output logic              finished,
  output logic              last
);

  localparam int TW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;

  typedef enum logic [2:0] {
    S_WIPE,
    S_IDLE,
    S_TICK,
    S_DIRTY,
    S_EMIT,
    S_TAB
  } state_t;

  state_t          state;
  logic            ph;
  logic [TW-1:0]   cnt;
  logic [TW-1:0]   total;
  logic            tick_phase;
  logic [SW-1:0]   wipe_addr;
  logic [SW-1:0]   tab_idx;
  logic [2:0]      tab_cmd;
  logic            tab_flag;
  logic [8:0]      tab_fc;

  ssdq_pkg::anim_t mem [SPRITE_COUNT];
  ssdq_pkg::anim_t rd;
  ssdq_pkg::anim_t mem_wd;
  logic            mem_we;
  logic [SW-1:0]   mem_addr;

  ssdq_pkg::job_t  new_job;
  ssdq_pkg::job_t  head;
  logic [TW-1:0]   at;
  logic            full;
  logic            take;
  logic            ins;
  logic            rot;
  logic [SW-1:0]   head_idx;
  logic            head_auto;
  logic            step_last;
  logic [8:0]      resolved;
  logic [7:0]      adv_frame;
  logic [8:0]      wrap_frame;

  assign busy = (state != S_IDLE);
  assign take = start && !busy;
  assign ins  = take && (cmd == ssdq_pkg::CMD_ADD) && first_cycle;
  assign rot  = ph && ((state == S_TICK) || (state == S_DIRTY) || (state == S_EMIT));

  always_comb begin
    new_job.sprite = sprite_id;
    new_job.frames = num_frames;
    new_job.frame  = frame_req;
    new_job.layer  = layer;
    new_job.x      = pos_x;
    new_job.y      = pos_y;
    new_job.style  = draw_style;
  end

  ssdq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk        (clk),
    .ins        (ins),
    .rot        (rot),
    .new_job    (new_job),
    .total      (total),
    .wrap_frame (wrap_frame),
    .head       (head),
    .at         (at),
    .full       (full)
  );

  assign head_idx  = SW'(ssdq_pkg::sprite_mod(head.sprite, SPRITE_COUNT));
  assign head_auto = (head.frame == ssdq_pkg::FRAME_AUTO);
  assign step_last = (cnt + TW'(1) == total);

  // Frame advance: step below the last frame, else wrap when looping, else hold.
  always_comb begin
    if ($signed({2'b00, rd.frame}) < $signed({1'b0, head.frames}) - 10'sd1) begin
      adv_frame = rd.frame + 8'd1;
    end else if (rd.loop) begin
      adv_frame = 8'd0;
    end else begin
      adv_frame = rd.frame;
    end
  end

  // Animated frame, mirrored when the sprite plays in reverse; a fixed frame passes as is.
  always_comb begin
    if (!head_auto) begin
      resolved = head.frame;
    end else if (rd.reverse) begin
      resolved = 9'({1'b0, head.frames} - 10'd1 - {2'b00, rd.frame});
    end else begin
      resolved = {1'b0, rd.frame};
    end
    wrap_frame = (state == S_EMIT) ? resolved : head.frame;
  end

  // Table port: one address for the read and the write-back of a step.
  always_comb begin
    mem_we = 1'b0;
    mem_wd = rd;
    if (state == S_WIPE) begin
      mem_addr = wipe_addr;
    end else if (state == S_TAB) begin
      mem_addr = tab_idx;
    end else begin
      mem_addr = head_idx;
    end
    case (state)
      S_WIPE: begin
        mem_we = 1'b1;
        mem_wd = '{frame: 8'd0, loop: 1'b1, reverse: 1'b0, dirty: 1'b1};
      end
      S_TICK: begin
        mem_we       = ph && head_auto && rd.dirty;
        mem_wd.frame = adv_frame;
        mem_wd.dirty = 1'b0;
      end
      S_DIRTY: begin
        mem_we       = ph;
        mem_wd.dirty = 1'b1;
      end
      S_TAB: begin
        mem_we = ph && (tab_cmd != ssdq_pkg::CMD_QUERY);
        case (tab_cmd)
          ssdq_pkg::CMD_LOOP:    mem_wd.loop    = tab_flag;
          ssdq_pkg::CMD_REVERSE: mem_wd.reverse = tab_flag;
          ssdq_pkg::CMD_RSTFRM:  mem_wd.frame   = 8'd0;
          default:               mem_wd         = rd;
        endcase
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd <= mem[mem_addr];
  end

  // Sequencer, list count and registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WIPE;
      ph         <= 1'b0;
      cnt        <= '0;
      total      <= '0;
      tick_phase <= 1'b0;
      wipe_addr  <= '0;
      valid      <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_WIPE: begin
          wipe_addr <= wipe_addr + SW'(1);
          if (wipe_addr == SW'(SPRITE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          ph  <= 1'b0;
          cnt <= '0;
          if (take) begin
            tab_idx  <= SW'(ssdq_pkg::sprite_mod(sprite_id, SPRITE_COUNT));
            tab_cmd  <= cmd;
            tab_flag <= flag;
            tab_fc   <= num_frames;
            unique case (cmd) inside
              ssdq_pkg::CMD_CLEAR: begin
                total <= '0;
              end
              ssdq_pkg::CMD_ADD: begin
                valid      <= 1'b1;
                kind       <= ssdq_pkg::KIND_ADD;
                position   <= first_cycle ? 7'(at) : 7'h7F;
                stored     <= first_cycle && !full;
                out_sprite <= '0;
                out_frame  <= '0;
                out_x      <= '0;
                out_y      <= '0;
                out_style  <= '0;
                finished   <= 1'b0;
                last       <= 1'b0;
                if (first_cycle && !full) begin
                  total <= total + TW'(1);
                end
              end
              ssdq_pkg::CMD_SUBMIT: begin
                if (first_cycle) begin
                  tick_phase <= !tick_phase;
                end
                if (total != '0) begin
                  state <= (first_cycle && tick_phase) ? S_TICK : S_EMIT;
                end
              end
              ssdq_pkg::CMD_LOOP, ssdq_pkg::CMD_REVERSE,
              ssdq_pkg::CMD_RSTFRM, ssdq_pkg::CMD_QUERY: begin
                state <= S_TAB;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_TICK, S_DIRTY, S_EMIT: begin
          ph <= !ph;
          if (ph) begin
            if (state == S_EMIT) begin
              valid      <= 1'b1;
              kind       <= ssdq_pkg::KIND_DRAW;
              position   <= '0;
              stored     <= 1'b0;
              out_sprite <= head.sprite;
              out_frame  <= resolved;
              out_x      <= head.x;
              out_y      <= head.y;
              out_style  <= head.style;
              finished   <= 1'b0;
              last       <= step_last;
            end
            if (step_last) begin
              cnt <= '0;
              if (state == S_TICK) begin
                state <= S_DIRTY;
              end else if (state == S_DIRTY) begin
                state <= S_EMIT;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              cnt <= cnt + TW'(1);
            end
          end
        end
        S_TAB: begin
          ph <= !ph;
          if (ph) begin
            state <= S_IDLE;
            if (tab_cmd == ssdq_pkg::CMD_QUERY) begin
              valid      <= 1'b1;
              kind       <= ssdq_pkg::KIND_QUERY;
              position   <= '0;
              stored     <= 1'b0;
              out_sprite <= '0;
              out_frame  <= '0;
              out_x      <= '0;
              out_y      <= '0;
              out_style  <= '0;
              finished   <= (({1'b0, rd.frame} + 9'd1) == tab_fc);
              last       <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
